[src/tde_pkg.sv]
package tde_pkg;

  localparam int unsigned DictDepth = 1024;
  localparam int unsigned MaxGroup  = 16;
  localparam int unsigned CodeW     = $clog2(DictDepth);
  localparam int unsigned CntW      = $clog2(DictDepth + 1);
  localparam int unsigned SlotW     = $clog2(MaxGroup);
  localparam int unsigned FillW     = $clog2(MaxGroup + 1);
  localparam int unsigned AddrW     = CodeW + SlotW;
  localparam logic [31:0] PadWord   = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    CFG_GROUP_SIZE = 1'b0,
    CFG_CODE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] value;
    logic        last;
    logic [9:0]  read_code;
    logic [3:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  code;
    logic [4:0]  value_count;
    logic        is_new;
    logic        overflow;
    logic [31:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic [4:0] index;
    logic [9:0] data;
  } cfg_item_t;

  // tuple memory port
  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    logic [31:0]      wr_data;
  } tbuf_req_t;

  // dictionary memory port
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [31:0]      wr_data;
  } dict_req_t;

endpackage

[src/tde_if.sv]
interface tde_in_if;
  logic               valid;
  logic               ready;
  tde_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tde_out_if;
  logic               valid;
  logic               ready;
  tde_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tde_cfg_if;
  logic               valid;
  logic               ready;
  tde_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/tuple_dictionary_encoder_core.sv]
// channel  dir  beat contents
// in_if    in   req_type, value, last, read_code, read_slot
// out_if   out  code, value_count, is_new, overflow, read_value
// cfg_if   in   index, data (0 group_size, 1 code_limit)
// a push that does not complete a tuple only stores its word; a read passes through ST_READ
// a complete tuple scans stored entries word by word through the dictionary
// memory port and, on a miss with room left, copies the tuple padded to
// MaxGroup words into a new entry
// reset clears fill and entry counts; memories hold no reset value
// input stalls while a result waits or a tuple or read is in work
module tuple_dictionary_encoder_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tde_in_if.sink    in_if,
  tde_out_if.source out_if,
  tde_cfg_if.sink   cfg_if
);
  tde_pkg::tbuf_req_t         tbuf_req;
  tde_pkg::dict_req_t         dict_req;
  logic [31:0]                tbuf_rd, dict_rd;
  logic                       busy;
  logic [tde_pkg::CntW-1:0]   entry_cnt;

  tde_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if, .cfg_if,
    .tbuf_o(tbuf_req), .tbuf_rd_i(tbuf_rd),
    .dict_o(dict_req), .dict_rd_i(dict_rd),
    .busy_o(busy), .entry_cnt_o(entry_cnt)
  );

  tde_tuple_mem u_tbuf (.clk_i, .req_i(tbuf_req), .rd_data_o(tbuf_rd));
  tde_dict_mem  u_dict (.clk_i, .req_i(dict_req), .rd_data_o(dict_rd));

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_if.ready) else $error("accept while busy");
  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_cnt <= tde_pkg::CntW'(tde_pkg::DictDepth)) else $error("entry count");
  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) && out_if.data.is_new |-> entry_cnt == $past(entry_cnt) + 1'b1)
    else $error("new without growth");
  a_wr_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dict_req.wr_en |-> busy) else $error("stray write");
endmodule

[src/tde_tuple_mem.sv]
module tde_tuple_mem (
  input  logic               clk_i,
  input  tde_pkg::tbuf_req_t req_i,
  output logic [31:0]        rd_data_o
);
  logic [31:0] mem_q [tde_pkg::MaxGroup];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end
endmodule

[src/tde_dict_mem.sv]
module tde_dict_mem (
  input  logic               clk_i,
  input  tde_pkg::dict_req_t req_i,
  output logic [31:0]        rd_data_o
);
  logic [31:0] mem_q [tde_pkg::DictDepth * tde_pkg::MaxGroup];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end
endmodule

[src/tde_ctrl.sv]
module tde_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  tde_in_if.sink              in_if,
  tde_out_if.source           out_if,
  tde_cfg_if.sink             cfg_if,
  output tde_pkg::tbuf_req_t  tbuf_o,
  input  logic [31:0]         tbuf_rd_i,
  output tde_pkg::dict_req_t  dict_o,
  input  logic [31:0]         dict_rd_i,
  output logic                busy_o,
  output logic [tde_pkg::CntW-1:0] entry_cnt_o
);
  localparam int unsigned SlotW = tde_pkg::SlotW;
  localparam int unsigned CodeW = tde_pkg::CodeW;
  localparam int unsigned CntW  = tde_pkg::CntW;
  localparam int unsigned FillW = tde_pkg::FillW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_COPY,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic [4:0]             group_q;
  logic [9:0]             limit_q;
  logic [FillW-1:0]       fill_q;
  logic [CntW-1:0]        entry_q;
  logic [FillW-1:0]       grp_eff_q;
  logic [FillW-1:0]       count_q;
  logic [CntW-1:0]        ent_q;
  logic [FillW-1:0]       slot_q;
  logic                   rd_pend_q;
  logic [SlotW-1:0]       rd_slot_q;
  logic                   mism_q;
  tde_pkg::out_item_t     out_q;
  logic                   out_valid_q;

  logic [FillW-1:0] grp_eff;
  logic [FillW-1:0] fill_inc;
  logic             accept, complete;
  logic [31:0]      tword;

  assign grp_eff = (group_q == 5'd0) ? FillW'(1) :
                   (group_q > 5'(tde_pkg::MaxGroup)) ? FillW'(tde_pkg::MaxGroup) :
                   FillW'(group_q);
  assign fill_inc = (fill_q + FillW'(1) > FillW'(tde_pkg::MaxGroup)) ?
                    FillW'(tde_pkg::MaxGroup) : fill_q + FillW'(1);
  assign complete = (fill_inc >= grp_eff) || in_if.data.last;
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;
  assign busy_o = (state_q != ST_IDLE);
  assign entry_cnt_o = entry_q;

  // slots at or past the real count read as padding
  assign tword = (FillW'(rd_slot_q) >= count_q) ? tde_pkg::PadWord : tbuf_rd_i;

  always_comb begin
    tbuf_o = '0;
    dict_o = '0;
    if (accept && in_if.data.req_type == tde_pkg::REQ_PUSH) begin
      tbuf_o.wr_en   = 1'b1;
      tbuf_o.wr_addr = fill_q[SlotW-1:0];
      tbuf_o.wr_data = in_if.data.value;
    end
    if (accept && in_if.data.req_type == tde_pkg::REQ_READ) begin
      dict_o.rd_en   = 1'b1;
      dict_o.rd_addr = {in_if.data.read_code, in_if.data.read_slot};
    end
    if ((state_q == ST_CMP || state_q == ST_COPY) && slot_q < FillW'(tde_pkg::MaxGroup)) begin
      tbuf_o.rd_en   = 1'b1;
      tbuf_o.rd_addr = slot_q[SlotW-1:0];
      dict_o.rd_en   = (state_q == ST_CMP);
      dict_o.rd_addr = {ent_q[CodeW-1:0], slot_q[SlotW-1:0]};
    end
    if (state_q == ST_COPY && rd_pend_q) begin
      dict_o.wr_en   = 1'b1;
      dict_o.wr_addr = {entry_q[CodeW-1:0], rd_slot_q};
      dict_o.wr_data = tword;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      group_q     <= 5'd4;
      limit_q     <= 10'd1023;
      fill_q      <= '0;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      mism_q      <= 1'b0;
      grp_eff_q   <= '0;
      count_q     <= '0;
      ent_q       <= '0;
      slot_q      <= '0;
      rd_slot_q   <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_if.valid) begin
        if (cfg_if.data.index == 5'(tde_pkg::CFG_GROUP_SIZE)) begin
          group_q <= cfg_if.data.data[4:0];
        end else if (cfg_if.data.index == 5'(tde_pkg::CFG_CODE_LIMIT)) begin
          limit_q <= cfg_if.data.data;
        end
      end
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_if.data.req_type == tde_pkg::REQ_READ) begin
              out_q.code        <= in_if.data.read_code;
              out_q.value_count <= '0;
              out_q.is_new      <= 1'b0;
              out_q.overflow    <= !(CntW'(in_if.data.read_code) < entry_q);
              out_q.read_value  <= '0;
              state_q           <= ST_READ;
            end else if (complete) begin
              count_q   <= (fill_inc < grp_eff) ? fill_inc : grp_eff;
              grp_eff_q <= grp_eff;
              fill_q    <= '0;
              ent_q     <= '0;
              slot_q    <= '0;
              rd_pend_q <= 1'b0;
              mism_q    <= 1'b0;
              state_q   <= ST_CMP;
            end else begin
              fill_q <= fill_inc;
            end
          end
        end
        ST_READ: begin
          if (!out_q.overflow) begin
            out_q.read_value <= dict_rd_i;
          end
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_CMP: begin
          // slot_q leads by one: data for rd_slot_q arrives now
          if (ent_q >= entry_q) begin
            out_q.value_count <= 5'(count_q);
            out_q.read_value  <= '0;
            if (entry_q > CntW'(limit_q) || entry_q >= CntW'(tde_pkg::DictDepth)) begin
              out_q.code     <= '0;
              out_q.is_new   <= 1'b0;
              out_q.overflow <= 1'b1;
              out_valid_q    <= 1'b1;
              state_q        <= ST_IDLE;
            end else begin
              slot_q    <= '0;
              rd_pend_q <= 1'b0;
              state_q   <= ST_COPY;
            end
          end else begin
            logic miss;
            logic done;
            miss = mism_q || (rd_pend_q && tword != dict_rd_i);
            done = rd_pend_q && (FillW'(rd_slot_q) + FillW'(1) >= grp_eff_q);
            if (done && !miss) begin
              out_q.code        <= ent_q[CodeW-1:0];
              out_q.value_count <= 5'(count_q);
              out_q.is_new      <= 1'b0;
              out_q.overflow    <= 1'b0;
              out_q.read_value  <= '0;
              out_valid_q       <= 1'b1;
              state_q           <= ST_IDLE;
            end else if (miss) begin
              ent_q     <= ent_q + CntW'(1);
              slot_q    <= '0;
              rd_pend_q <= 1'b0;
              mism_q    <= 1'b0;
            end else begin
              rd_pend_q <= (slot_q < grp_eff_q);
              rd_slot_q <= slot_q[SlotW-1:0];
              slot_q    <= (slot_q < grp_eff_q) ? slot_q + FillW'(1) : slot_q;
            end
          end
        end
        ST_COPY: begin
          if (slot_q < FillW'(tde_pkg::MaxGroup)) begin
            rd_pend_q <= 1'b1;
            rd_slot_q <= slot_q[SlotW-1:0];
            slot_q    <= slot_q + FillW'(1);
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q && rd_slot_q == SlotW'(tde_pkg::MaxGroup - 1)) begin
            out_q.code     <= entry_q[CodeW-1:0];
            out_q.is_new   <= 1'b1;
            out_q.overflow <= 1'b0;
            entry_q        <= entry_q + CntW'(1);
            out_valid_q    <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

[dv/tde_scoreboard.sv]
`timescale 1ns / 100ps

module tde_scoreboard
  import tde_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tde_in_if    in_mon,
  tde_out_if   out_mon,
  tde_cfg_if   cfg_mon,
  output int   errors_o,
  output int   pending_o,
  output int   results_o
);

  logic [4:0]  group_size_q;
  logic [9:0]  code_limit_q;
  logic [31:0] tuple_words[MaxGroup];
  logic [4:0]  fill_q;
  logic [31:0] dict_words[DictDepth][MaxGroup];
  logic [10:0] entry_cnt_q;
  out_item_t   expected_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    errors_o++;
  endtask

  // returns 1 when the beat yields a result
  function automatic logic encode_beat(input in_item_t it, output out_item_t r);
    int grp;
    int cnt;
    int hit;
    bit same;
    r = '0;
    if (it.req_type == REQ_READ) begin
      r.code = it.read_code;
      if (11'(it.read_code) < entry_cnt_q) r.read_value = dict_words[it.read_code][it.read_slot];
      else r.overflow = 1'b1;
      return 1'b1;
    end
    grp = (group_size_q == 0) ? 1 : (group_size_q > MaxGroup) ? MaxGroup : int'(group_size_q);
    tuple_words[fill_q[3:0]] = it.value;
    fill_q++;
    if (fill_q > MaxGroup) fill_q = 5'(MaxGroup);
    if (fill_q < grp && !it.last) return 1'b0;
    cnt = (fill_q < grp) ? int'(fill_q) : grp;
    for (int i = cnt; i < MaxGroup; i++) tuple_words[i] = PadWord;
    fill_q = '0;
    r.value_count = 5'(cnt);
    hit = -1;
    for (int e = 0; e < entry_cnt_q && hit < 0; e++) begin
      same = 1;
      for (int i = 0; i < grp; i++) if (dict_words[e][i] != tuple_words[i]) same = 0;
      if (same) hit = e;
    end
    if (hit >= 0) begin
      r.code = 10'(hit);
    end else if (entry_cnt_q > 11'(code_limit_q) || entry_cnt_q >= DictDepth) begin
      r.overflow = 1'b1;
    end else begin
      for (int i = 0; i < MaxGroup; i++) dict_words[entry_cnt_q][i] = tuple_words[i];
      r.code = entry_cnt_q[9:0];
      r.is_new = 1'b1;
      entry_cnt_q++;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    out_item_t got;
    if (!rst_ni) begin
      group_size_q <= 5'd4;
      code_limit_q <= 10'd1023;
      fill_q       <= '0;
      entry_cnt_q  <= '0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        results_o++;
        if (expected_q.size() == 0) begin
          report("unexpected beat", 32'(got.code), 32'd0);
        end else begin
          exp_item = expected_q.pop_front();
          if (got.code != exp_item.code)
            report("code", 32'(got.code), 32'(exp_item.code));
          if (got.value_count != exp_item.value_count)
            report("value_count", 32'(got.value_count), 32'(exp_item.value_count));
          if (got.is_new != exp_item.is_new)
            report("is_new", 32'(got.is_new), 32'(exp_item.is_new));
          if (got.overflow != exp_item.overflow)
            report("overflow", 32'(got.overflow), 32'(exp_item.overflow));
          if (got.read_value != exp_item.read_value)
            report("read_value", got.read_value, exp_item.read_value);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (encode_beat(in_mon.data, exp_item)) expected_q.push_back(exp_item);
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.data.index == 5'(CFG_GROUP_SIZE)) group_size_q = cfg_mon.data.data[4:0];
        else if (cfg_mon.data.index == 5'(CFG_CODE_LIMIT)) code_limit_q = cfg_mon.data.data;
      end
    end
    pending_o = expected_q.size();
  end

  initial begin
    errors_o  = 0;
    pending_o = 0;
    results_o = 0;
  end

endmodule

[dv/tb_tuple_dictionary_encoder_core.sv]
`timescale 1ns / 100ps

module tb_tuple_dictionary_encoder_core;
  import tde_pkg::*;

  localparam logic [4:0] CfgUnused = 5'd5;
  localparam int         HoldBeat  = 120;
  localparam int         CycleMax  = 3000000;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   results;
  int   cycles;
  int   pushes;
  int   reads;

  tde_in_if  in_if();
  tde_out_if out_if();
  tde_cfg_if cfg_if();

  tuple_dictionary_encoder_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  tde_scoreboard scb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .cfg_mon  (cfg_if),
    .errors_o (errors),
    .pending_o(pending),
    .results_o(results)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleMax) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(input in_item_t it);
    int gap;
    gap = ((pushes + reads) % 100 < 30) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    forever begin
      @(negedge clk_i);
      if (in_if.ready) break;
    end
    @(posedge clk_i);
    if (it.req_type == REQ_READ) reads++;
    else pushes++;
  endtask

  task automatic push_value(input logic [31:0] v, input logic last);
    in_item_t it;
    it.req_type  = REQ_PUSH;
    it.value     = v;
    it.last      = last;
    it.read_code = 10'($urandom_range(0, 1023));
    it.read_slot = 4'($urandom_range(0, 15));
    send_beat(it);
  endtask

  task automatic read_word(input logic [9:0] c, input logic [3:0] s);
    in_item_t it;
    it.req_type  = REQ_READ;
    it.value     = $urandom;
    it.last      = 1'($urandom_range(0, 1));
    it.read_code = c;
    it.read_slot = s;
    send_beat(it);
  endtask

  task automatic write_reg(input logic [4:0] idx, input logic [9:0] d);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.data  <= d;
    forever begin
      @(negedge clk_i);
      if (cfg_if.ready) break;
    end
    @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // result side backpressure, with one long hold so the block fills up
  initial begin
    int gap;
    int n;
    n = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = (n % 80 < 25) ? 0 : $urandom_range(0, 14);
      if (n == HoldBeat) gap = 700;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (out_if.valid) break;
      end
      @(posedge clk_i);
      n++;
    end
  end

  initial begin
    logic [31:0] pool[6];
    logic [4:0]  grp_set[8];
    logic [9:0]  lim_set[8];
    int          r;
    logic [31:0] v;
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, $urandom, $urandom};
    grp_set = '{5'd1, 5'd2, 5'd8, 5'd16, 5'd0, 5'd31, 5'd3, 5'd4};
    lim_set = '{10'd60, 10'd60, 10'd60, 10'd60, 10'd40, 10'd0, 10'd60, 10'd1023};
    cycles = 0;
    pushes = 0;
    reads  = 0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, group of four
    push_value(32'h0, 0);
    push_value(32'hFFFF_FFFF, 0);
    push_value(32'h1, 0);
    push_value(32'h2, 0);
    push_value(32'h0, 0);
    push_value(32'hFFFF_FFFF, 0);
    push_value(32'h1, 0);
    push_value(32'h2, 0);
    push_value(32'h5, 1);
    push_value(32'hFFFF_FFFF, 1);
    read_word(10'd0, 4'd0);
    read_word(10'd0, 4'd3);
    read_word(10'd1, 4'd15);
    read_word(10'd2, 4'd1);
    read_word(10'd3, 4'd0);
    read_word(10'd1023, 4'd15);
    // group change mid tuple
    drain();
    write_reg(5'(CFG_GROUP_SIZE), 10'd16);
    push_value(32'hA5A5_A5A5, 0);
    push_value(32'h5A5A_5A5A, 0);
    push_value(32'h1234_5678, 0);
    drain();
    write_reg(5'(CFG_GROUP_SIZE), 10'd2);
    push_value(32'h0, 0);
    // full dictionary per limit
    drain();
    write_reg(5'(CFG_CODE_LIMIT), 10'd0);
    write_reg(CfgUnused, 10'h3FF);
    push_value(32'hDEAD_BEEF, 0);
    push_value(32'hCAFE_F00D, 0);
    push_value(32'h0, 0);
    push_value(32'hFFFF_FFFF, 0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(5'(CFG_GROUP_SIZE), {5'd0, grp_set[ph]});
      write_reg(5'(CFG_CODE_LIMIT), lim_set[ph]);
      for (int k = 0; k < 138; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          v = ($urandom_range(0, 99) < 15) ? $urandom : pool[$urandom_range(0, 5)];
          push_value(v, $urandom_range(0, 99) < 8);
        end else if (r < 92) begin
          read_word(10'($urandom_range(0, 70)), 4'($urandom_range(0, 15)));
        end else begin
          read_word(10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
        end
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("sent %0d pushes and %0d reads, checked %0d results", pushes, reads, results);
    $display("group sizes 0..31 and code limits 0..1023 exercised, one long output hold");
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
